// ----- sv/wtsp_pkg.sv -----
// ---------------------------------------------------------------------------
// wtsp_pkg: shared types and constants of the world-to-screen projection
// Widths of the clip, divide and screen datapaths, register codes, helpers.
// ---------------------------------------------------------------------------
package wtsp_pkg;

  localparam int unsigned POS_W  = 32;  // Q16.16 input coordinate
  localparam int unsigned COEF_W = 16;  // Q4.12 coefficient
  localparam int unsigned PROD_W = POS_W + COEF_W;
  localparam int unsigned CLIP_W = 50;  // signed clip value in Q.28
  localparam int unsigned MAG_W  = 48;  // clip magnitude, always below 2^48
  localparam int unsigned WIN_W  = 14;
  localparam int unsigned H_W    = WIN_W - 1;
  localparam int unsigned NUM_W  = H_W + MAG_W;  // half size times magnitude
  localparam int unsigned QBITS  = 34;           // quotient bits kept
  localparam int unsigned NLO_W  = QBITS;        // numerator bits fed one a stage
  localparam int unsigned QUO_W  = QBITS + 1;    // quotient with clamp value
  localparam int unsigned DIV_LAT = QBITS + 1;
  localparam int unsigned ROW_W  = 64;
  localparam int unsigned ADDR_W = 6;

  // Smallest clip w in Q.28 that counts as visible (w >= 0.1).
  localparam logic signed [CLIP_W-1:0] W_MIN = CLIP_W'(26843546);

  localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(64'h0000_0000_0000_1000);
  localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(64'h0000_0000_1000_0000);
  localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(64'h0000_1000_0000_0000);
  localparam logic [ROW_W-1:0] ROW3_RST = ROW_W'(64'h1000_0000_0000_0000);
  localparam logic [WIN_W-1:0] WW_RST   = WIN_W'(1920);
  localparam logic [WIN_W-1:0] WH_RST   = WIN_W'(1080);

  typedef enum logic [2:0] {
    REG_ROW0 = 3'd0,
    REG_ROW1 = 3'd1,
    REG_ROW2 = 3'd2,
    REG_ROW3 = 3'd3,
    REG_WW   = 3'd4,
    REG_WH   = 3'd5
  } reg_idx_e;

  // Status that travels beside the divider.
  typedef struct packed {
    logic valid;
    logic visible;
    logic neg_x;
    logic neg_y;
  } side_t;

  function automatic logic signed [COEF_W-1:0] coef(input logic [ROW_W-1:0] row,
                                                    input int unsigned k);
    coef = $signed(row[COEF_W*k +: COEF_W]);
  endfunction

  function automatic logic [POS_W-1:0] sat32(input logic signed [CLIP_W-1:0] v);
    logic signed [CLIP_W-1:0] hi;
    logic signed [CLIP_W-1:0] lo;
    hi = CLIP_W'(64'sd2147483647);
    lo = -CLIP_W'(64'sd2147483648);
    if (v > hi) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[POS_W-1:0];
    end
  endfunction

endpackage

// ----- sv/wtsp_div.sv -----
// ---------------------------------------------------------------------------
// wtsp_div: pipelined restoring divider
// One quotient bit per stage; quotients of 2^34 or more come out as 2^34.
// ---------------------------------------------------------------------------
module wtsp_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [wtsp_pkg::NUM_W-1:0]    num_i,
  input  logic [wtsp_pkg::MAG_W-1:0]    den_i,
  output logic [wtsp_pkg::QUO_W-1:0]    quo_o
);
  import wtsp_pkg::*;

  localparam int unsigned TOP_W = NUM_W - (NLO_W - 16);

  logic [MAG_W-1:0] rem_q [0:QBITS];
  logic [MAG_W-1:0] den_q [0:QBITS];
  logic [NLO_W-1:0] nlo_q [0:QBITS];
  logic [QBITS-1:0] quo_q [0:QBITS];
  logic             ovf_q [0:QBITS];
  logic             ovf_d;

  // The numerator is num_i shifted left by 16; its upper part must stay below
  // the divisor, or the quotient would not fit in QBITS bits.
  assign ovf_d = MAG_W'(num_i[NUM_W-1:NUM_W-TOP_W]) >= den_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= ovf_d;
      rem_q[0] <= ovf_d ? '0 : MAG_W'(num_i[NUM_W-1:NUM_W-TOP_W]);
      den_q[0] <= den_i;
      nlo_q[0] <= {num_i[NLO_W-17:0], 16'b0};
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    logic [MAG_W:0] trial;
    logic [MAG_W:0] diff;
    logic           ge;
    assign trial = {rem_q[k], nlo_q[k][NLO_W-1-k]};
    assign diff  = trial - {1'b0, den_q[k]};
    assign ge    = trial >= {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        den_q[k+1] <= den_q[k];
        nlo_q[k+1] <= nlo_q[k];
        quo_q[k+1] <= {quo_q[k][QBITS-2:0], ge};
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo_o = ovf_q[QBITS] ? QUO_W'(1) << QBITS : {1'b0, quo_q[QBITS]};

endmodule

// ----- sv/world_to_screen_projection.sv -----
// ---------------------------------------------------------------------------
// world_to_screen_projection: perspective projection and viewport map
// Multiplies a Q16.16 point by a 4x4 Q4.12 matrix, divides by clip w and
// maps the result to a window, saturating to Q16.16.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake               word
//  -------  ---------  ----------------------  ---------------------------
//  in       input      in_valid_i / in_stall_o  pos_x_i, pos_y_i, pos_z_i
//  out      output     out_valid_o/out_stall_i  visible_o, screen_x_o/_y_o
//  cfg      input      APB (psel..pready)       six registers at 8*i
//
// One word enters per cycle while the output is not stalled. The pipeline
// has four stages of matrix multiply, add, visibility test and numerator
// product, 35 stages of the divider (a load stage, then one quotient bit
// per stage), and the output register. Reset clears the valid bits and
// loads the identity matrix and a 1920 by 1080 window. A stall on a held
// output word freezes the whole pipeline at once, so nothing is dropped or
// repeated; the input stall follows it in the same cycle.
module world_to_screen_projection (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [wtsp_pkg::POS_W-1:0]        pos_x_i,
  input  logic [wtsp_pkg::POS_W-1:0]        pos_y_i,
  input  logic [wtsp_pkg::POS_W-1:0]        pos_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              visible_o,
  output logic [wtsp_pkg::POS_W-1:0]        screen_x_o,
  output logic [wtsp_pkg::POS_W-1:0]        screen_y_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wtsp_pkg::ADDR_W-1:0]       paddr,
  input  logic [wtsp_pkg::ROW_W-1:0]        pwdata,
  output logic [wtsp_pkg::ROW_W-1:0]        prdata,
  output logic                              pready
);
  import wtsp_pkg::*;

  // Configuration registers.
  logic [ROW_W-1:0] row_q [0:3];
  logic [WIN_W-1:0] ww_q;
  logic [WIN_W-1:0] wh_q;
  reg_idx_e         cfg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW0_RST;
      row_q[1] <= ROW1_RST;
      row_q[2] <= ROW2_RST;
      row_q[3] <= ROW3_RST;
      ww_q     <= WW_RST;
      wh_q     <= WH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROW0: row_q[0] <= pwdata;
        REG_ROW1: row_q[1] <= pwdata;
        REG_ROW2: row_q[2] <= pwdata;
        REG_ROW3: row_q[3] <= pwdata;
        REG_WW:   ww_q     <= pwdata[WIN_W-1:0];
        REG_WH:   wh_q     <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROW0: prdata = row_q[0];
      REG_ROW1: prdata = row_q[1];
      REG_ROW2: prdata = row_q[2];
      REG_ROW3: prdata = row_q[3];
      REG_WW:   prdata = ROW_W'(ww_q);
      REG_WH:   prdata = ROW_W'(wh_q);
      default:  prdata = '0;
    endcase
  end

  // Half sizes in whole pixels.
  logic [H_W-1:0] hw;
  logic [H_W-1:0] hh;
  assign hw = ww_q[WIN_W-1:1];
  assign hh = wh_q[WIN_W-1:1];

  // The whole pipeline moves together unless a held result is stalled.
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage 1: the nine products of the x, y and w rows.
  logic                     v1_q;
  logic signed [PROD_W-1:0] p_q [0:2][0:2];
  logic signed [COEF_W-1:0] t_q [0:2];
  logic signed [POS_W-1:0]  pos [0:2];
  logic [1:0]               rsel [0:2];

  assign pos[0]  = $signed(pos_x_i);
  assign pos[1]  = $signed(pos_y_i);
  assign pos[2]  = $signed(pos_z_i);
  assign rsel[0] = 2'd0;
  assign rsel[1] = 2'd1;
  assign rsel[2] = 2'd3;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (en) begin
          p_q[r][c] <= PROD_W'(pos[c]) * PROD_W'(coef(row_q[rsel[r]], c));
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        t_q[r] <= coef(row_q[rsel[r]], 3);
      end
    end
  end

  // Stage 2: clip x, y and w in Q.28; the translation is shifted up by 16.
  logic                     v2_q;
  logic signed [CLIP_W-1:0] clip_q [0:2];

  for (genvar r = 0; r < 3; r++) begin : g_sum
    always_ff @(posedge clk_i) begin
      if (en) begin
        clip_q[r] <= CLIP_W'(p_q[r][0]) + CLIP_W'(p_q[r][1]) + CLIP_W'(p_q[r][2])
                   + (CLIP_W'(t_q[r]) <<< 16);
      end
    end
  end

  // Stage 3: visibility test, signs and magnitudes.
  logic             v3_q;
  logic             vis3_q;
  logic             negx3_q;
  logic             negy3_q;
  logic [MAG_W-1:0] magx3_q;
  logic [MAG_W-1:0] magy3_q;
  logic [MAG_W-1:0] w3_q;
  logic [CLIP_W-1:0] absx;
  logic [CLIP_W-1:0] absy;

  assign absx = clip_q[0][CLIP_W-1] ? -clip_q[0] : clip_q[0];
  assign absy = clip_q[1][CLIP_W-1] ? -clip_q[1] : clip_q[1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis3_q  <= clip_q[2] >= W_MIN;
      negx3_q <= clip_q[0][CLIP_W-1];
      negy3_q <= clip_q[1][CLIP_W-1];
      magx3_q <= absx[MAG_W-1:0];
      magy3_q <= absy[MAG_W-1:0];
      w3_q    <= clip_q[2][MAG_W-1:0];
    end
  end

  // Stage 4: numerators h * |c|. An invisible point divides by one so the
  // divider never sees a zero divisor; its result is discarded anyway.
  logic             v4_q;
  side_t            side4_q;
  logic [NUM_W-1:0] nx4_q;
  logic [NUM_W-1:0] ny4_q;
  logic [MAG_W-1:0] w4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side4_q.visible <= vis3_q;
      side4_q.neg_x   <= negx3_q;
      side4_q.neg_y   <= negy3_q;
      nx4_q <= NUM_W'(hw) * NUM_W'(magx3_q);
      ny4_q <= NUM_W'(hh) * NUM_W'(magy3_q);
      w4_q  <= vis3_q ? w3_q : MAG_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Divider stages with the status carried alongside.
  logic [QUO_W-1:0] qx;
  logic [QUO_W-1:0] qy;
  side_t            side_q [0:DIV_LAT-1];
  side_t            side4;

  always_comb begin
    side4.valid   = v4_q;
    side4.visible = side4_q.visible;
    side4.neg_x   = side4_q.neg_x;
    side4.neg_y   = side4_q.neg_y;
  end

  wtsp_div u_div_x (.clk_i, .en_i(en), .num_i(nx4_q), .den_i(w4_q), .quo_o(qx));
  wtsp_div u_div_y (.clk_i, .en_i(en), .num_i(ny4_q), .den_i(w4_q), .quo_o(qy));

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k] <= '0;
      end else if (en) begin
        side_q[k] <= (k == 0) ? side4 : side_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Final stage: offsets from the window center (y inverted), then saturate.
  side_t                    sd;
  logic signed [CLIP_W-1:0] offx;
  logic signed [CLIP_W-1:0] offy;
  logic signed [CLIP_W-1:0] sumx;
  logic signed [CLIP_W-1:0] sumy;
  logic                     visible_q;
  logic [POS_W-1:0]         sx_q;
  logic [POS_W-1:0]         sy_q;

  assign sd   = side_q[DIV_LAT-1];
  assign offx = sd.neg_x ? -CLIP_W'(qx) : CLIP_W'(qx);
  assign offy = sd.neg_y ? -CLIP_W'(qy) : CLIP_W'(qy);
  assign sumx = (CLIP_W'(hw) <<< 16) + offx;
  assign sumy = (CLIP_W'(hh) <<< 16) - offy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sd.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      visible_q <= sd.visible;
      sx_q      <= sd.visible ? sat32(sumx) : '0;
      sy_q      <= sd.visible ? sat32(sumy) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;

endmodule
